### design/cl_pkg.sv
// Shared constants for the compact list block: operation codes, status codes
// and field widths. No dependencies.
`default_nettype none

package cl_pkg;

    // Field widths of the request and response payloads.
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 5;
    localparam int ECNT_W  = 6;

    // Operation codes carried in the request.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes carried in the response.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

endpackage

`default_nettype wire

### design/cl_if.sv
// Valid/ready channel interfaces for the compact list block.
// Depends on cl_pkg for the payload widths.
`default_nettype none

// Request channel: operation and value.
interface cl_req_if;
    logic                                valid;
    logic                                ready;
    logic [cl_pkg::OP_W-1:0]             op;
    logic signed [cl_pkg::DATA_W-1:0]    value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: status, matching slot and entry count.
interface cl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [cl_pkg::STAT_W-1:0]           status;
    logic [cl_pkg::POS_W-1:0]            position;
    logic [cl_pkg::ECNT_W-1:0]           entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

`default_nettype wire

### design/cl_ram.sv
// Entry store of the compact list: one write port, one read port with
// registered read data. Depends on cl_pkg for the data width.
`default_nettype none

module cl_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [cl_pkg::DATA_W-1:0]   i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [cl_pkg::DATA_W-1:0]   o_rd_data
);

    logic [cl_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [cl_pkg::DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data appears the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/compact_list_insert_search_delete.sv
// Compact list of signed 32-bit values with insert, search and delete.
//
// Requests arrive on i_req (op, value) and one response per request leaves on
// o_rsp (status, position, entry_count); each moves by a valid/ready transfer.
// The block works on one request at a time: i_req.ready is high only while
// no request is in progress and no response is waiting.
//
// Insert writes its entry as it is taken and offers its response in the next
// cycle. Search walks the stored entries through the single read port of the
// entry memory, one entry per cycle. Delete does the same walk and then moves
// every later entry down one slot through the same read and write ports, one
// entry per cycle, and drains the last move before the response.
//
// Reset clears the count and returns the sequencer to idle; the memory itself
// is not cleared, since only slots below the count are ever read. When the
// receiver stalls, the response is held in its registers and no new request
// is taken until it is transferred.
`default_nettype none

module compact_list_insert_search_delete #(
    parameter int DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cl_req_if.sink     i_req,
    cl_rsp_if.source   o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_ptr, n_ptr;
    logic                            r_pend, n_pend;
    logic [AW-1:0]                   r_cidx, n_cidx;
    logic signed [cl_pkg::DATA_W-1:0] r_value, n_value;
    logic                            r_del, n_del;
    logic [cl_pkg::STAT_W-1:0]       r_status, n_status;
    logic [AW-1:0]                   r_pos, n_pos;

    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [cl_pkg::DATA_W-1:0]       wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [cl_pkg::DATA_W-1:0]       rd_data;
    logic                            issue;
    logic                            match;
    logic                            req_xfer;

    cl_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake and shared compare unit.
    assign req_xfer = i_req.valid && i_req.ready;
    assign issue    = r_ptr < r_count;
    assign match    = r_pend && (rd_data == r_value);
    assign rd_addr  = r_ptr[AW-1:0];

    // Sequencer next-state logic and memory port control.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_cidx   = r_cidx;
        n_value  = r_value;
        n_del    = r_del;
        n_status = r_status;
        n_pos    = r_pos;
        wr_en    = 1'b0;
        wr_addr  = r_count[AW-1:0];
        wr_data  = i_req.value;
        rd_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_value  = i_req.value;
                    n_del    = (i_req.op == cl_pkg::OP_DELETE);
                    n_status = cl_pkg::ST_OK;
                    n_pos    = '0;
                    n_state  = S_RESP;
                    if (i_req.op == cl_pkg::OP_INSERT) begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_status = cl_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end else if (i_req.op == cl_pkg::OP_SEARCH ||
                                 i_req.op == cl_pkg::OP_DELETE) begin
                        if (r_count == '0) begin
                            n_status = cl_pkg::ST_MISSING;
                        end else begin
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SRCH;
                        end
                    end
                end
            end

            S_SRCH: begin
                // Issue the next read while comparing the entry read last cycle.
                rd_en  = issue;
                n_pend = issue;
                n_cidx = r_ptr[AW-1:0];
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (match) begin
                    n_pos = r_cidx;
                    if (r_del) begin
                        n_ptr   = CW'(r_cidx) + CW'(1);
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (!issue) begin
                    n_status = cl_pkg::ST_MISSING;
                    n_pos    = '0;
                    n_state  = S_RESP;
                end
            end

            S_SHIFT: begin
                // Read slot i+1 and write its value into slot i in the next cycle.
                rd_en  = issue;
                n_pend = issue;
                n_cidx = r_ptr[AW-1:0];
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cidx - AW'(1);
                    wr_data = rd_data;
                end
                if (!issue && !r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_ptr    <= n_ptr;
        r_cidx   <= n_cidx;
        r_value  <= n_value;
        r_del    <= n_del;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    // Channel outputs.
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_RESP);
    assign o_rsp.status      = r_status;
    assign o_rsp.position    = cl_pkg::POS_W'(r_pos);
    assign o_rsp.entry_count = cl_pkg::ECNT_W'(r_count);

    // The count never exceeds the list capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // A new request is never taken while a response is still offered.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while response pending");

    // Shifting only writes slots below the last stored entry.
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && wr_en) |-> (CW'(wr_addr) < r_count - CW'(1)))
        else $error("shift writes outside the stored entries");

    // An insert into a list with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && i_req.op == cl_pkg::OP_INSERT && r_count < CW'(DEPTH))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // A delete that found its entry leaves one entry fewer at the response.
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_RESP)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the count");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for compact_list_insert_search_delete: a directed table,
// then random insert/search/delete phases, checked against a list model.
// Depends on cl_pkg, the cl_req_if/cl_rsp_if channels and the block itself.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cl_pkg::*;

    localparam int LIST_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4 * LIST_DEPTH;
    localparam int N_DIRECTED   = 23;
    localparam int MAX_REPORTS  = 10;

    // Operation code the block leaves unused; it still answers it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [ECNT_W-1:0] entry_count;
    } list_rsp_t;

    // One request of the directed table; typed rows carry their answer.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         position;
        logic [ECNT_W-1:0]        entry_count;
    } dir_row_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cl_req_if req_if();
    cl_rsp_if rsp_if();

    compact_list_insert_search_delete #(.DEPTH(LIST_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // Model of the stored list and the answers still owed by the block.
    logic signed [DATA_W-1:0] list_vals [LIST_DEPTH];
    int                       list_len = 0;
    list_rsp_t                answers_due [$];

    // Run state shared between processes.
    logic steady   = 1'b0;
    logic hold_off = 1'b0;
    int   accepted_cnt = 0;
    int   answered_cnt = 0;
    int   mismatches   = 0;
    int   cycle_cnt    = 0;

    // Coverage tallies for the summary.
    int n_insert = 0, n_full = 0, n_search = 0, n_search_miss = 0;
    int n_delete = 0, n_delete_miss = 0, n_unused = 0, peak_len = 0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{OP_SEARCH, 32'sd0,          1'b1, ST_MISSING, 5'd0, 6'd0},
        '{OP_DELETE, -32'sd1,         1'b1, ST_MISSING, 5'd0, 6'd0},
        '{OP_UNUSED, VAL_MAX,         1'b1, ST_OK,      5'd0, 6'd0},
        '{OP_INSERT, VAL_MIN,         1'b1, ST_OK,      5'd0, 6'd1},
        '{OP_INSERT, VAL_MAX,         1'b1, ST_OK,      5'd1, 6'd2},
        '{OP_INSERT, -32'sd1,         1'b1, ST_OK,      5'd2, 6'd3},
        '{OP_INSERT, 32'sd0,          1'b1, ST_OK,      5'd3, 6'd4},
        '{OP_INSERT, VAL_MAX,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_INSERT, -32'sd1,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_SEARCH, VAL_MAX,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_SEARCH, -32'sd1,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_SEARCH, VAL_MIN,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_SEARCH, 32'sd1,          1'b1, ST_MISSING, 5'd0, 6'd6},
        '{OP_DELETE, VAL_MAX,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_SEARCH, VAL_MAX,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_DELETE, -32'sd1,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_DELETE, -32'sd1,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_DELETE, 32'sd12345,      1'b1, ST_MISSING, 5'd0, 6'd3},
        '{OP_UNUSED, -32'sd1,         1'b1, ST_OK,      5'd0, 6'd3},
        '{OP_DELETE, 32'sd0,          1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_DELETE, VAL_MIN,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_DELETE, VAL_MAX,         1'b0, ST_OK,      5'd0, 6'd0},
        '{OP_INSERT, 32'shAAAA_AAAA,  1'b1, ST_OK,      5'd0, 6'd1}
    };

    // Apply one request to the list model and return the answer it should get.
    function automatic list_rsp_t apply_to_list(input logic [OP_W-1:0] op,
                                                input logic signed [DATA_W-1:0] v);
        list_rsp_t r;
        int        slot;
        int        i;
        r.status   = ST_OK;
        r.position = '0;
        slot = -1;
        for (i = 0; i < list_len; i++)
            if (slot < 0 && list_vals[i] == v) slot = i;
        case (op)
            OP_INSERT: begin
                n_insert++;
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    list_vals[list_len] = v;
                    r.position = POS_W'(list_len);
                    list_len++;
                end
            end
            OP_SEARCH: begin
                n_search++;
                if (slot < 0) begin
                    r.status = ST_MISSING;
                    n_search_miss++;
                end else begin
                    r.position = POS_W'(slot);
                end
            end
            OP_DELETE: begin
                n_delete++;
                if (slot < 0) begin
                    r.status = ST_MISSING;
                    n_delete_miss++;
                end else begin
                    // Close the gap: every later entry moves down one slot.
                    for (i = slot; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                    r.position = POS_W'(slot);
                end
            end
            default: n_unused++;
        endcase
        r.entry_count = ECNT_W'(list_len);
        if (list_len > peak_len) peak_len = list_len;
        return r;
    endfunction

    // Operation mix per phase; the unused code shows up now and then.
    function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
        int r;
        r = $urandom_range(99);
        if (r < 2) return OP_UNUSED;
        case (mix)
            MIX_FILL:  return (r < 80) ? OP_INSERT : (r < 90) ? OP_SEARCH : OP_DELETE;
            MIX_DRAIN: return (r < 15) ? OP_INSERT : (r < 35) ? OP_SEARCH : OP_DELETE;
            default:   return (r < 36) ? OP_INSERT : (r < 68) ? OP_SEARCH : OP_DELETE;
        endcase
    endfunction

    // Values lean on stored entries and a narrow range so that hits and
    // duplicates are common; the rest are extremes or fully random words.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45 && list_len > 0)
            return list_vals[$urandom_range(list_len - 1)];
        if (r < 70)
            return $signed(DATA_W'($urandom_range(8))) - 32'sd4;
        if (r < 76) begin
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $signed($urandom);
    endfunction

    // Offer one request, with random idle cycles first, and wait for its transfer.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] v);
        while (!steady && $urandom_range(99) < 21) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.value <= v;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        accepted_cnt++;
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial begin
        mix_t      mix;
        int        phase_left;
        int        random_sent;
        int        idx;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] v;
        list_rsp_t                predicted;

        req_if.valid <= 1'b0;
        req_if.op    <= OP_INSERT;
        req_if.value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: typed answers where obvious, the model elsewhere.
        for (idx = 0; idx < N_DIRECTED; idx++) begin
            send_request(directed_rows[idx].op, directed_rows[idx].value);
            predicted = apply_to_list(directed_rows[idx].op, directed_rows[idx].value);
            if (directed_rows[idx].typed)
                answers_due.push_back('{directed_rows[idx].status,
                                        directed_rows[idx].position,
                                        directed_rows[idx].entry_count});
            else
                answers_due.push_back(predicted);
        end

        // Random phases; the first one fills the list past full.
        mix         = MIX_FILL;
        phase_left  = 70;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(2))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_BLEND;
                endcase
                phase_left = $urandom_range(70, 20);
            end
            // A stretch in the middle runs with no idle cycles on either side.
            steady <= (random_sent >= 600 && random_sent < 760);
            op = pick_op(mix);
            v  = pick_value();
            send_request(op, v);
            answers_due.push_back(apply_to_list(op, v));
            phase_left--;
            if (op != OP_UNUSED) random_sent++;
        end
        req_if.valid <= 1'b0;

        // Wait for every outstanding response, then let the block settle.
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("tb_top: %0d requests, %0d responses; inserts %0d (%0d on a full list),",
                 accepted_cnt, answered_cnt, n_insert, n_full);
        $display("tb_top: searches %0d (%0d misses), deletes %0d (%0d misses), unused %0d, peak fill %0d",
                 n_search, n_search_miss, n_delete, n_delete_miss, n_unused, peak_len);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", mismatches);
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Receiver: random back-pressure, and every response transfer is checked
    // against the oldest answer still owed.
    initial begin
        list_rsp_t want;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                answered_cnt++;
                if (answers_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("tb_top: response %0d arrived with nothing pending",
                                 answered_cnt);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.position !== want.position
                        || rsp_if.entry_count !== want.entry_count) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"tb_top: response %0d expected status %0d position %0d",
                                      " count %0d, got status %0d position %0d count %0d"},
                                     answered_cnt, want.status, want.position,
                                     want.entry_count, rsp_if.status, rsp_if.position,
                                     rsp_if.entry_count);
                        mismatches++;
                    end
                end
            end
            rsp_if.ready <= !hold_off && (steady || $urandom_range(99) >= 21);
        end
    end

    // Long receiver hold-off while the sender keeps offering requests.
    initial begin
        int n;
        wait (accepted_cnt >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_top: timed out after %0d cycles, %0d responses owed",
                 cycle_cnt, answers_due.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

### sim.f
design/cl_pkg.sv
design/cl_if.sv
design/cl_ram.sv
design/compact_list_insert_search_delete.sv
tb/tb_top.sv
